// ----- rtl/v4alu_pkg.sv -----
// ----------------------------------------------------------------------------
// v4alu_pkg
// shared types and constants for the four-component vector alu
// ----------------------------------------------------------------------------
package v4alu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int LANES     = 4;
	localparam int SUM_W     = 66;
	localparam int QW        = 32 + FRAC_BITS;
	localparam int ROOT_W    = 31;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_SCL  = 4'd3,
		OP_DOT  = 4'd4,
		OP_LEN  = 4'd5,
		OP_DIST = 4'd6,
		OP_NORM = 4'd7,
		OP_EQ   = 4'd8
	} op_t;

	localparam logic [0:0] REG_THRESH = 1'd0;

	typedef struct packed {
		logic        valid;
		logic [3:0]  op;
		logic [30:0] thresh;
		logic [31:0] sc;
	} ctl_t;

	// lane result before merging
	typedef struct packed {
		logic [31:0] r;
		logic        ov;
		logic [63:0] prod;
		logic [63:0] sq;
		logic [32:0] mag;
		logic        neg;
	} lane_t;

	function automatic logic [31:0] sat32(input logic signed [65:0] v, output logic ov);
		ov = 1'b0;
		if (v > 66'sh0_7FFF_FFFF) begin
			ov = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -66'sh0_8000_0000) begin
			ov = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

endpackage

// ----- rtl/v4alu_lane.sv -----
// ----------------------------------------------------------------------------
// v4alu_lane
// one component lane: add/sub/product/square, registered
// ----------------------------------------------------------------------------
module v4alu_lane (
	input  logic              clk,
	input  logic              en,
	input  logic [3:0]        op,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	input  logic [31:0]       sc,
	output v4alu_pkg::lane_t  res_s1
);
	import v4alu_pkg::*;

	logic signed [32:0] d;
	logic [32:0] m;
	logic signed [31:0] mb;
	logic signed [63:0] p;
	logic [63:0] sq;
	logic signed [65:0] w;
	logic [31:0] r;
	logic ov;

	always_comb begin
		d  = (op == OP_LEN || op == OP_NORM) ? 33'(signed'(a))
		     : 33'(signed'(a)) - 33'(signed'(b));
		m  = d[32] ? 33'(-d) : d;
		mb = (op == OP_SCL) ? signed'(sc) : signed'(b);
		p  = signed'(a) * mb;
		sq = 64'(m) * 64'(m);
		r  = '0;
		ov = 1'b0;
		case (op)
			OP_ADD: begin
				w = 66'(signed'(a)) + 66'(signed'(b));
				r = sat32(w, ov);
			end
			OP_SUB: begin
				w = 66'(signed'(a)) - 66'(signed'(b));
				r = sat32(w, ov);
			end
			OP_MUL, OP_SCL: begin
				w = 66'(p >>> FRAC_BITS);
				r = sat32(w, ov);
			end
			default: w = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1.r    <= r;
			res_s1.ov   <= ov;
			res_s1.prod <= p;
			res_s1.sq   <= sq;
			res_s1.mag  <= m;
			res_s1.neg  <= a[31];
		end
	end

endmodule

// ----- rtl/v4alu_sqrt.sv -----
// ----------------------------------------------------------------------------
// v4alu_sqrt
// pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
module v4alu_sqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] rad,
	output logic [30:0] root
);
	import v4alu_pkg::*;

	logic [61:0] rad_s [ROOT_W];
	logic [32:0] rem_s [ROOT_W];
	logic [30:0] r_s   [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic [61:0] rad_i;
		logic [32:0] rem_i;
		logic [30:0] r_i;
		logic [34:0] t;
		logic [32:0] trial;
		logic ge;
		if (i == 0) begin : g_first
			assign rad_i = rad;
			assign rem_i = '0;
			assign r_i   = '0;
		end else begin : g_next
			assign rad_i = rad_s[i-1];
			assign rem_i = rem_s[i-1];
			assign r_i   = r_s[i-1];
		end
		// bring down the next two radicand bits and try a one bit
		assign t     = {rem_i, rad_i[61-2*i -: 2]};
		assign trial = {r_i, 2'b01};
		assign ge    = t >= 35'(trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[i] <= rad_i;
				rem_s[i] <= ge ? 33'(t - 35'(trial)) : t[32:0];
				r_s[i]   <= {r_i[29:0], ge};
			end
		end
	end

	assign root = r_s[ROOT_W-1];

endmodule

// ----- rtl/v4alu_div.sv -----
// ----------------------------------------------------------------------------
// v4alu_div
// pipelined restoring divider for normalize, one quotient bit per stage
// ----------------------------------------------------------------------------
module v4alu_div (
	input  logic           clk,
	input  logic           en,
	input  logic [47:0]    num,
	input  logic [30:0]    den,
	output logic [47:0]    quo
);
	import v4alu_pkg::*;

	logic [47:0] n_s [QW];
	logic [30:0] d_s [QW];
	logic [31:0] rm_s [QW];
	logic [47:0] q_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		logic [47:0] n_i;
		logic [30:0] d_i;
		logic [31:0] rm_i;
		logic [47:0] q_i;
		logic [32:0] t;
		logic ge;
		if (i == 0) begin : g_first
			assign n_i  = num;
			assign d_i  = den;
			assign rm_i = '0;
			assign q_i  = '0;
		end else begin : g_next
			assign n_i  = n_s[i-1];
			assign d_i  = d_s[i-1];
			assign rm_i = rm_s[i-1];
			assign q_i  = q_s[i-1];
		end
		assign t  = {rm_i, n_i[QW-1-i]};
		assign ge = t >= 33'(d_i);
		always_ff @(posedge clk) begin
			if (en) begin
				n_s[i]  <= n_i;
				d_s[i]  <= d_i;
				rm_s[i] <= ge ? 32'(t - 33'(d_i)) : t[31:0];
				q_s[i]  <= {q_i[QW-2:0], ge};
			end
		end
	end

	assign quo = q_s[QW-1];

endmodule

// ----- rtl/vec4_vector_alu.sv -----
// ----------------------------------------------------------------------------
// vec4_vector_alu
// four-lane q16.16 vector alu with pipelined sqrt and normalize divide
// ----------------------------------------------------------------------------
// channel  | signals                                   | dir
// in       | in_valid/in_ready, opcode a_* b_* scalar_in | request in
// out      | out_valid/out_ready, r_* scalar_out flags | request out
// cfg      | apb psel penable pwrite paddr pwdata      | register writes
//
// requests pass the lane, merge, sqrt, length and divider stages and
// the output register; one request per cycle unless out stalls.
// reset clears all valid bits and sets the threshold to 1.
// a stall on out freezes the whole pipeline; the output register holds.
module vec4_vector_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  opcode,
	input  logic [31:0] a_x, a_y, a_z, a_w,
	input  logic [31:0] b_x, b_y, b_z, b_w,
	input  logic [31:0] scalar_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] r_x, r_y, r_z, r_w,
	output logic [31:0] scalar_out,
	output logic        equal_flag,
	output logic        overflow_flag,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import v4alu_pkg::*;

	localparam int DEPTH = 1 + 1 + ROOT_W + 1 + QW;

	logic [30:0] thresh_q;
	logic adv;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESH) ? {1'b0, thresh_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= 31'd1;
		end else if (psel && penable && pwrite && paddr[2] == REG_THRESH) begin
			thresh_q <= pwdata[30:0];
		end
	end

	// out register free or being taken
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// lanes are combinational into their stage-1 register; gate with adv
	lane_t ln_s1 [LANES];
	logic [31:0] av [LANES];
	logic [31:0] bv [LANES];
	assign av = '{a_x, a_y, a_z, a_w};
	assign bv = '{b_x, b_y, b_z, b_w};

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		v4alu_lane u_lane (
			.clk(clk), .en(adv), .op(opcode), .a(av[i]), .b(bv[i]), .sc(scalar_in),
			.res_s1(ln_s1[i])
		);
	end

	// control pipeline
	ctl_t ctl_s [DEPTH];
	ctl_t ctl_in;
	assign ctl_in = '{valid: in_valid && in_ready, op: opcode, thresh: thresh_q, sc: scalar_in};

	// merge stage (s2): sums
	logic signed [65:0] dot_hi, dot_lo;
	logic [SUM_W-1:0] ssum;
	always_comb begin
		dot_hi = '0;
		dot_lo = '0;
		ssum   = '0;
		for (int i = 0; i < LANES; i++) begin
			dot_hi += 66'(signed'(ln_s1[i].prod) >>> FRAC_BITS);
			dot_lo += 66'(ln_s1[i].prod[FRAC_BITS-1:0]);
			ssum   += SUM_W'(ln_s1[i].sq);
		end
	end

	logic [31:0] r_s2 [LANES];
	logic [LANES-1:0] ovl_s2;
	logic [32:0] mag_s2 [LANES];
	logic [LANES-1:0] neg_s2;
	logic [31:0] so_s2;
	logic ov_s2, eq_s2, big_s2;
	logic [61:0] rad_s2;
	logic [31:0] so_c;
	logic ov_c;
	logic signed [65:0] dsum;

	assign dsum = dot_hi + (dot_lo >>> FRAC_BITS);
	always_comb begin
		so_c = sat32(dsum, ov_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < LANES; i++) begin
				r_s2[i]   <= ln_s1[i].r;
				ovl_s2[i] <= ln_s1[i].ov;
				mag_s2[i] <= ln_s1[i].mag;
				neg_s2[i] <= ln_s1[i].neg;
			end
			so_s2  <= so_c;
			ov_s2  <= ov_c;
			big_s2 <= ssum[SUM_W-1:62] != '0;
			rad_s2 <= ssum[61:0];
			eq_s2  <= !signed'(ctl_s[0].sc[31]) && ctl_s[0].sc != '0
			          && ssum[SUM_W-1:64] == '0
			          && 66'(ssum[63:0]) < (66'(ctl_s[0].sc) << FRAC_BITS);
		end
	end

	// sqrt pipeline runs on adv through a delay-matched data path
	logic [30:0] root;
	logic [61:0] rad_g;
	assign rad_g = rad_s2;
	v4alu_sqrt u_sqrt (.clk(clk), .en(adv), .rad(rad_g), .root(root));

	// side data delay line, advanced together with the sqrt stages
	typedef struct packed {
		logic [31:0] r0, r1, r2, r3;
		logic [3:0]  ovl;
		logic [32:0] m0, m1, m2, m3;
		logic [3:0]  neg;
		logic [31:0] so;
		logic        ov, eq, big;
	} side_t;
	side_t side_in;
	side_t side_s [ROOT_W];
	assign side_in = '{r0: r_s2[0], r1: r_s2[1], r2: r_s2[2], r3: r_s2[3], ovl: ovl_s2,
		m0: mag_s2[0], m1: mag_s2[1], m2: mag_s2[2], m3: mag_s2[3], neg: neg_s2,
		so: so_s2, ov: ov_s2, eq: eq_s2, big: big_s2};
	for (genvar i = 0; i < ROOT_W; i++) begin : g_side
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) side_s[i] <= side_in;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) side_s[i] <= side_s[i-1];
			end
		end
	end

	// length stage, then divider launch
	side_t sd_l;
	logic [30:0] len_l;
	logic lov_l, nrm_l;
	always_ff @(posedge clk) begin
		if (adv) begin
			sd_l  <= side_s[ROOT_W-1];
			len_l <= side_s[ROOT_W-1].big ? 31'h7FFF_FFFF : root;
			lov_l <= side_s[ROOT_W-1].big;
			nrm_l <= !side_s[ROOT_W-1].big ? (root > ctl_s[ROOT_W+1].thresh)
			                               : (31'h7FFF_FFFF > ctl_s[ROOT_W+1].thresh);
		end
	end

	logic [47:0] quo [LANES];
	logic [32:0] mg [LANES];
	assign mg = '{sd_l.m0, sd_l.m1, sd_l.m2, sd_l.m3};
	for (genvar i = 0; i < LANES; i++) begin : g_div
		v4alu_div u_div (
			.clk(clk), .en(adv), .num(48'(mg[i][31:0]) << FRAC_BITS),
			.den(len_l == '0 ? 31'd1 : len_l), .quo(quo[i])
		);
	end

	typedef struct packed {
		side_t sd;
		logic [30:0] len;
		logic lov, nrm;
	} post_t;
	post_t post_in;
	post_t post_s [QW];
	assign post_in = '{sd: sd_l, len: len_l, lov: lov_l, nrm: nrm_l};
	for (genvar i = 0; i < QW; i++) begin : g_post
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (adv) post_s[i] <= post_in;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (adv) post_s[i] <= post_s[i-1];
			end
		end
	end

	// control pipe shifts with the data; valid marks accepted requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) ctl_s[i] <= '0;
		end else if (adv) begin
			ctl_s[0] <= ctl_in;
			for (int i = 1; i < DEPTH; i++) ctl_s[i] <= ctl_s[i-1];
		end
	end

	// final merge
	post_t pf;
	ctl_t cf;
	logic [31:0] fr [LANES];
	logic [31:0] fso;
	logic feq, fov;
	logic [31:0] rv [LANES];
	logic [LANES-1:0] qov;
	assign pf = post_s[QW-1];
	assign cf = ctl_s[DEPTH-1];
	assign rv = '{pf.sd.r0, pf.sd.r1, pf.sd.r2, pf.sd.r3};

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			fr[i]  = rv[i];
			qov[i] = 1'b0;
		end
		fso = '0;
		feq = 1'b0;
		fov = 1'b0;
		case (op_t'(cf.op))
			OP_ADD, OP_SUB, OP_MUL, OP_SCL: fov = |pf.sd.ovl;
			OP_DOT: begin
				for (int i = 0; i < LANES; i++) fr[i] = '0;
				fso = pf.sd.so;
				fov = pf.sd.ov;
			end
			OP_LEN, OP_DIST: begin
				for (int i = 0; i < LANES; i++) fr[i] = '0;
				fso = {1'b0, pf.len};
				fov = pf.lov;
			end
			OP_NORM: begin
				fso = {1'b0, pf.len};
				fov = pf.lov;
				for (int i = 0; i < LANES; i++) begin
					if (pf.nrm) begin
						if (quo[i][47:31] != '0) begin
							qov[i] = 1'b1;
							fr[i]  = pf.sd.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
							if (pf.sd.neg[i] && quo[i] == 48'h8000_0000) qov[i] = 1'b0;
						end else begin
							fr[i] = pf.sd.neg[i] ? 32'(-quo[i][31:0]) : quo[i][31:0];
						end
					end
				end
				if (!pf.nrm) begin
					fr = '{pf.sd.m0[31:0], pf.sd.m1[31:0], pf.sd.m2[31:0], pf.sd.m3[31:0]};
					for (int i = 0; i < LANES; i++)
						if (pf.sd.neg[i]) fr[i] = 32'(-fr[i]);
				end
				fov = pf.lov | (|qov);
			end
			OP_EQ: begin
				for (int i = 0; i < LANES; i++) fr[i] = '0;
				feq = pf.sd.eq;
			end
			default: begin
				for (int i = 0; i < LANES; i++) fr[i] = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= cf.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cf.valid) begin
			r_x <= fr[0];
			r_y <= fr[1];
			r_z <= fr[2];
			r_w <= fr[3];
			scalar_out    <= fso;
			equal_flag    <= feq;
			overflow_flag <= fov;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
		$stable({r_x, r_y, r_z, r_w, scalar_out, equal_flag, overflow_flag}))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("stalled without pending result");

endmodule

// ----- sim/vec4_vector_alu_tb.sv -----
// ----------------------------------------------------------------------------
// vec4_vector_alu_tb
// self-checking bench for the q16.16 vector alu: directed corner requests and
// random traffic with random stalls, compared against an in-bench predictor
// ----------------------------------------------------------------------------
module vec4_vector_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import v4alu_pkg::*;

	localparam int LATENCY = 83;
	localparam int N_RANDOM = 1750;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [2:0] ADDR_THRESH = 3'(4 * REG_THRESH);

	typedef struct {
		logic [3:0]  op;
		logic [31:0] a [4];
		logic [31:0] b [4];
		logic [31:0] sc;
	} alu_req_t;

	typedef struct {
		logic [31:0] r [4];
		logic [31:0] so;
		logic        eq;
		logic        ov;
	} alu_res_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] opcode = '0;
	logic [31:0] a_x = '0, a_y = '0, a_z = '0, a_w = '0;
	logic [31:0] b_x = '0, b_y = '0, b_z = '0, b_w = '0;
	logic [31:0] scalar_in = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] r_x, r_y, r_z, r_w, scalar_out;
	logic equal_flag, overflow_flag;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	vec4_vector_alu DUT (.*);

	alu_req_t pending_reqs [$];
	alu_res_t expected_results [$];
	logic [30:0] thresh_model = 31'd1;
	int error_count = 0;
	longint cycle_count = 0;
	bit hold_sender = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------- predictor ----------------
	function automatic longint floor_q(longint p);
		return p >>> FRAC_BITS;
	endfunction

	function automatic logic [31:0] clamp32(longint v, ref logic ov);
		if (v > 64'sd2147483647) begin
			ov = 1'b1;
			return 32'h7FFF_FFFF;
		end
		if (v < -64'sd2147483648) begin
			ov = 1'b1;
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	// sum of squares of magnitudes, exact at 66 bits
	function automatic logic [65:0] sq_sum(logic [32:0] m [4]);
		logic [65:0] s;
		s = '0;
		for (int i = 0; i < 4; i++) s += 66'(m[i]) * 66'(m[i]);
		return s;
	endfunction

	function automatic logic [31:0] floor_sqrt(logic [65:0] s);
		logic [31:0] root;
		logic [31:0] c;
		root = '0;
		for (int k = 30; k >= 0; k--) begin
			c = root | (32'd1 << k);
			if (66'(c) * 66'(c) <= s) root = c;
		end
		return root;
	endfunction

	function automatic logic [31:0] vec_len(logic [32:0] m [4], ref logic ov);
		logic [65:0] s;
		s = sq_sum(m);
		if (s >= (66'd1 << 62)) begin
			ov = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return floor_sqrt(s);
	endfunction

	function automatic logic [32:0] mag33(longint v);
		return (v < 0) ? 33'(-v) : 33'(v);
	endfunction

	function automatic alu_res_t predict_alu(alu_req_t q, logic [30:0] thr);
		alu_res_t res;
		longint a [4], b [4], sc, acc, lo, p, qv;
		logic [32:0] m [4];
		logic [65:0] s;
		logic [31:0] len;
		logic ov;
		ov = 1'b0;
		for (int i = 0; i < 4; i++) begin
			a[i] = longint'($signed(q.a[i]));
			b[i] = longint'($signed(q.b[i]));
			res.r[i] = '0;
		end
		sc = longint'($signed(q.sc));
		res.so = '0;
		res.eq = 1'b0;
		case (q.op)
			OP_ADD: for (int i = 0; i < 4; i++) res.r[i] = clamp32(a[i] + b[i], ov);
			OP_SUB: for (int i = 0; i < 4; i++) res.r[i] = clamp32(a[i] - b[i], ov);
			OP_MUL: for (int i = 0; i < 4; i++)
				res.r[i] = clamp32(floor_q(a[i] * b[i]), ov);
			OP_SCL: for (int i = 0; i < 4; i++)
				res.r[i] = clamp32(floor_q(a[i] * sc), ov);
			OP_DOT: begin
				// the sum of four products can leave 64 bits: split each one
				acc = 0;
				lo = 0;
				for (int i = 0; i < 4; i++) begin
					p = a[i] * b[i];
					acc += floor_q(p);
					lo += p - (floor_q(p) <<< FRAC_BITS);
				end
				res.so = clamp32(acc + floor_q(lo), ov);
			end
			OP_LEN: begin
				for (int i = 0; i < 4; i++) m[i] = mag33(a[i]);
				res.so = vec_len(m, ov);
			end
			OP_DIST: begin
				for (int i = 0; i < 4; i++) m[i] = mag33(a[i] - b[i]);
				res.so = vec_len(m, ov);
			end
			OP_NORM: begin
				for (int i = 0; i < 4; i++) m[i] = mag33(a[i]);
				len = vec_len(m, ov);
				res.so = len;
				if (len > 32'(thr)) begin
					for (int i = 0; i < 4; i++) begin
						qv = longint'((64'(m[i]) << FRAC_BITS) / 64'(len));
						res.r[i] = clamp32(a[i] < 0 ? -qv : qv, ov);
					end
				end else begin
					for (int i = 0; i < 4; i++) res.r[i] = q.a[i];
				end
			end
			OP_EQ: begin
				if (sc > 0) begin
					for (int i = 0; i < 4; i++) m[i] = mag33(a[i] - b[i]);
					s = sq_sum(m);
					// 64-bit carry in the model means no match
					res.eq = (s < (66'd1 << 64)) && (s < (66'(sc) << FRAC_BITS));
				end
			end
			default: ;
		endcase
		res.ov = ov;
		return res;
	endfunction

	// ---------------- stimulus helpers ----------------
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 8)) - 4) << FRAC_BITS;
			3: return 32'($urandom_range(0, 1023)) - 32'd512;
			4, 5: return 32'($signed($urandom_range(0, 65535 * 4)) - 65535 * 2) << 4;
			default: return $urandom();
		endcase
	endfunction

	function automatic alu_req_t make_req(logic [3:0] op);
		alu_req_t q;
		q.op = op;
		for (int i = 0; i < 4; i++) begin
			q.a[i] = rand_word();
			q.b[i] = ($urandom_range(0, 3) == 0) ? q.a[i] + 32'($urandom_range(0, 64)) - 32'd32
				: rand_word();
		end
		q.sc = rand_word();
		return q;
	endfunction

	function automatic alu_req_t fill_req(logic [3:0] op, logic [31:0] av, logic [31:0] bv,
			logic [31:0] sv);
		alu_req_t q;
		q.op = op;
		for (int i = 0; i < 4; i++) begin
			q.a[i] = av;
			q.b[i] = bv;
		end
		q.sc = sv;
		return q;
	endfunction

	function automatic int pick_gap();
		case ($urandom_range(0, 19))
			0: return $urandom_range(10, 40);
			1, 2, 3, 4, 5: return $urandom_range(1, 3);
			default: return 0;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		error_count++;
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		thresh_model = data[30:0];
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// ---------------- driver ----------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_alu(pending_reqs.pop_front(), thresh_model));
				send_gap = pick_gap();
			end
			if (!(in_valid && !in_ready)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0 && !hold_sender) begin
					in_valid <= 1'b1;
					opcode <= pending_reqs[0].op;
					a_x <= pending_reqs[0].a[0];
					a_y <= pending_reqs[0].a[1];
					a_z <= pending_reqs[0].a[2];
					a_w <= pending_reqs[0].a[3];
					b_x <= pending_reqs[0].b[0];
					b_y <= pending_reqs[0].b[1];
					b_z <= pending_reqs[0].b[2];
					b_w <= pending_reqs[0].b[3];
					scalar_in <= pending_reqs[0].sc;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- monitor ----------------
	always @(posedge clk) begin
		alu_res_t w;
		logic [31:0] got [4];
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", 32'd0, 32'd0);
				end else begin
					w = expected_results.pop_front();
					got = '{r_x, r_y, r_z, r_w};
					for (int i = 0; i < 4; i++)
						if (got[i] !== w.r[i]) report_mismatch($sformatf("r[%0d]", i), got[i], w.r[i]);
					if (scalar_out !== w.so) report_mismatch("scalar_out", scalar_out, w.so);
					if (equal_flag !== w.eq) report_mismatch("equal_flag", 32'(equal_flag), 32'(w.eq));
					if (overflow_flag !== w.ov)
						report_mismatch("overflow_flag", 32'(overflow_flag), 32'(w.ov));
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				recv_gap = pick_gap();
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------- sequence ----------------
	initial begin
		logic [30:0] thr_list [4];
		thr_list = '{31'd0, 31'h7FFF_FFFF, 31'd196608, 31'd1};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at reset threshold
		for (int op = 0; op < 16; op++)
			pending_reqs.push_back(fill_req(op[3:0], 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
		pending_reqs.push_back(fill_req(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'd0));
		pending_reqs.push_back(fill_req(OP_SCL, 32'hFFFF_FFFF, 32'd0, 32'h0001_0000));
		pending_reqs.push_back(fill_req(OP_NORM, 32'd0, 32'd0, 32'd0));
		pending_reqs.push_back(fill_req(OP_NORM, 32'd1, 32'd0, 32'd0));
		pending_reqs.push_back(fill_req(OP_NORM, 32'hFFFE_0000, 32'd0, 32'd0));
		pending_reqs.push_back(fill_req(OP_EQ, 32'd5, 32'd5, 32'd0));
		pending_reqs.push_back(fill_req(OP_EQ, 32'd5, 32'd5, 32'hFFFF_FFFF));
		pending_reqs.push_back(fill_req(OP_EQ, 32'd0, 32'd1, 32'd1));
		pending_reqs.push_back(fill_req(OP_DIST, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0));
		wait_drained();
		repeat (LATENCY) @(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			apb_write(ADDR_THRESH, {1'b0, thr_list[ph]});
			for (int n = 0; n < N_RANDOM / 4; n++)
				pending_reqs.push_back(make_req(($urandom_range(0, 15) == 0)
					? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8))));
			// hold the sender once until the pipeline fully empties
			while (pending_reqs.size() > N_RANDOM / 8) @(posedge clk);
			hold_sender = 1'b1;
			while (expected_results.size() != 0 || in_valid) @(posedge clk);
			hold_sender = 1'b0;
			wait_drained();
			repeat (LATENCY) @(posedge clk);
		end

		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
